// ===== hdl/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared constants, codes and types of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 14;
    localparam int OFFSET_FRAC_DEF  = 4;

    localparam int NUM_AXES      = 3;
    localparam int CAL_SAMPLES_W = 14;
    localparam int THRESH_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;
    localparam int ACCEL_OUT_W   = 16;
    localparam int RATE_W        = 17;

    // 1/16.4 scale into 1/16 deg/s: x * 3996 >> 12
    localparam int                 SCALE_W     = 13;
    localparam logic signed [12:0] SCALE_MUL   = 13'sd3996;
    localparam int                 SCALE_SHIFT = 12;

    localparam logic [CAL_SAMPLES_W-1:0] CAL_SAMPLES_RST = 14'd8000;
    localparam logic [THRESH_W-1:0]      THRESH_RST      = 16'd100;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CAL  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAL_SAMPLES = 1'b0,
        REG_MOTION_THR  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CAL   = 2'd1,
        PH_READY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_CHECK,
        ST_SCALE,
        ST_DIVIDE,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic clear;
        logic sample_idle;
        logic sample_cal;
        logic sample_ready;
        logic scale;
        logic div_start;
        logic div_step;
        logic div_finish;
    } t_lane_ctl;

    typedef struct packed {
        logic                          moved;
        logic signed [ACCEL_OUT_W-1:0] accel;
        logic signed [RATE_W-1:0]      rate;
    } t_lane_stat;

endpackage

// ===== hdl/gbc_if.sv =====
// ----------------------------------------------------------------------------
// gbc_if
// Valid/ready channels for sensor requests in and results out.
// ----------------------------------------------------------------------------
interface gbc_in_if #(
    parameter int SAMPLE_WIDTH = gbc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic signed [SAMPLE_WIDTH-1:0] gyro_x;
    logic signed [SAMPLE_WIDTH-1:0] gyro_y;
    logic signed [SAMPLE_WIDTH-1:0] gyro_z;

    modport source (
        output valid, mode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        input  ready
    );
    modport sink (
        input  valid, mode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        output ready
    );
endinterface

interface gbc_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic signed [gbc_pkg::ACCEL_OUT_W-1:0]  accel_out_x;
    logic signed [gbc_pkg::ACCEL_OUT_W-1:0]  accel_out_y;
    logic signed [gbc_pkg::ACCEL_OUT_W-1:0]  accel_out_z;
    logic signed [gbc_pkg::RATE_W-1:0]       rate_x;
    logic signed [gbc_pkg::RATE_W-1:0]       rate_y;
    logic signed [gbc_pkg::RATE_W-1:0]       rate_z;
    logic                                    calibration_ok;

    modport source (
        output valid, kind, accel_out_x, accel_out_y, accel_out_z,
               rate_x, rate_y, rate_z, calibration_ok,
        input  ready
    );
    modport sink (
        input  valid, kind, accel_out_x, accel_out_y, accel_out_z,
               rate_x, rate_y, rate_z, calibration_ok,
        output ready
    );
endinterface

// ===== hdl/gyro_bias_calibrator.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_calibrator
// Gyro bias calibration and rate correction, three axis lanes in parallel.
// ----------------------------------------------------------------------------
// A start command enters calibration and leaves the block in accept. A sensor
// request while ready passes through accept, scale multiply and result load,
// which waits for a free output register; the block takes no new request
// until that result is loaded. A calibration request is accepted and then
// checked for motion, with a failure result on motion. The request that
// completes calibration also runs each lane's restoring divider, one quotient
// bit per cycle over SAMPLE_WIDTH + COUNT_WIDTH + 1 + OFFSET_FRACTION_BITS
// bits (35 at the defaults). Idle samples produce no result. Results sit in an
// output register, so a new request is taken while the previous result waits.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator #(
    parameter int SAMPLE_WIDTH         = gbc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH          = gbc_pkg::COUNT_WIDTH_DEF,
    parameter int OFFSET_FRACTION_BITS = gbc_pkg::OFFSET_FRAC_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gbc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    gbc_in_if.sink                           i_in,
    gbc_out_if.source                        o_out
);

    localparam int DVD_W = SAMPLE_WIDTH + COUNT_WIDTH + 1 + OFFSET_FRACTION_BITS;
    localparam int DCN_W = $clog2(DVD_W + 1);
    localparam int CNT_CMP_W = (COUNT_WIDTH > gbc_pkg::CAL_SAMPLES_W) ? COUNT_WIDTH
                                                                      : gbc_pkg::CAL_SAMPLES_W;

    gbc_pkg::t_state                     r_state, n_state;
    gbc_pkg::t_phase                     r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]              r_count, n_count;
    logic [DCN_W-1:0]                    r_div_cnt, n_div_cnt;
    logic                                r_res_kind, n_res_kind;
    logic                                r_res_ok, n_res_ok;
    logic [gbc_pkg::CAL_SAMPLES_W-1:0]   r_cal_samples;
    logic [gbc_pkg::THRESH_W-1:0]        r_threshold;

    gbc_pkg::t_lane_ctl             w_ctl;
    gbc_pkg::t_lane_stat            w_stat [gbc_pkg::NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] w_accel [gbc_pkg::NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] w_gyro  [gbc_pkg::NUM_AXES];
    logic                           w_in_acc;
    logic                           w_any_moved;
    logic                           w_out_free;
    logic                           w_load;
    logic                           w_cal_done;

    assign i_in.ready = (r_state == gbc_pkg::ST_ACCEPT);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_cal_done = CNT_CMP_W'(r_count) >= CNT_CMP_W'(r_cal_samples);

    assign w_accel[0] = i_in.accel_x;
    assign w_accel[1] = i_in.accel_y;
    assign w_accel[2] = i_in.accel_z;
    assign w_gyro[0]  = i_in.gyro_x;
    assign w_gyro[1]  = i_in.gyro_y;
    assign w_gyro[2]  = i_in.gyro_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_samples <= gbc_pkg::CAL_SAMPLES_RST;
            r_threshold   <= gbc_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            case (gbc_pkg::t_cfg_reg'(i_cfg_index))
                gbc_pkg::REG_CAL_SAMPLES: begin
                    r_cal_samples <= i_cfg_data[gbc_pkg::CAL_SAMPLES_W-1:0];
                end
                gbc_pkg::REG_MOTION_THR: begin
                    r_threshold <= i_cfg_data[gbc_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbc_pkg::ST_ACCEPT;
            r_phase    <= gbc_pkg::PH_IDLE;
            r_count    <= '0;
            r_div_cnt  <= '0;
            r_res_kind <= gbc_pkg::KIND_DATA;
            r_res_ok   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_div_cnt  <= n_div_cnt;
            r_res_kind <= n_res_kind;
            r_res_ok   <= n_res_ok;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_count    = r_count;
        n_div_cnt  = r_div_cnt;
        n_res_kind = r_res_kind;
        n_res_ok   = r_res_ok;
        w_ctl      = '0;
        w_load     = 1'b0;
        case (r_state)
            gbc_pkg::ST_ACCEPT: begin
                if (w_in_acc) begin
                    if (i_in.mode) begin
                        n_phase   = gbc_pkg::PH_CAL;
                        n_count   = '0;
                        w_ctl.clear = 1'b1;
                    end else begin
                        case (r_phase)
                            gbc_pkg::PH_READY: begin
                                w_ctl.sample_ready = 1'b1;
                                n_state = gbc_pkg::ST_SCALE;
                            end
                            gbc_pkg::PH_CAL: begin
                                w_ctl.sample_cal = 1'b1;
                                n_count = r_count + 1'b1;
                                n_state = gbc_pkg::ST_CHECK;
                            end
                            default: begin
                                w_ctl.sample_idle = 1'b1;
                            end
                        endcase
                    end
                end
            end
            gbc_pkg::ST_SCALE: begin
                w_ctl.scale = 1'b1;
                n_res_kind  = gbc_pkg::KIND_DATA;
                n_res_ok    = 1'b0;
                n_state     = gbc_pkg::ST_PUSH;
            end
            gbc_pkg::ST_CHECK: begin
                if (w_any_moved) begin
                    n_phase    = gbc_pkg::PH_IDLE;
                    n_res_kind = gbc_pkg::KIND_CAL;
                    n_res_ok   = 1'b0;
                    n_state    = gbc_pkg::ST_PUSH;
                end else if (w_cal_done) begin
                    w_ctl.div_start = 1'b1;
                    n_div_cnt = DCN_W'(DVD_W);
                    n_state   = gbc_pkg::ST_DIVIDE;
                end else begin
                    n_state = gbc_pkg::ST_ACCEPT;
                end
            end
            gbc_pkg::ST_DIVIDE: begin
                if (r_div_cnt != '0) begin
                    w_ctl.div_step = 1'b1;
                    n_div_cnt = r_div_cnt - 1'b1;
                end else begin
                    w_ctl.div_finish = 1'b1;
                    n_phase    = gbc_pkg::PH_READY;
                    n_res_kind = gbc_pkg::KIND_CAL;
                    n_res_ok   = 1'b1;
                    n_state    = gbc_pkg::ST_PUSH;
                end
            end
            gbc_pkg::ST_PUSH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = gbc_pkg::ST_ACCEPT;
                end
            end
            default: begin
                n_state = gbc_pkg::ST_ACCEPT;
            end
        endcase
    end

    for (genvar a = 0; a < gbc_pkg::NUM_AXES; a++) begin : g_lane
        gbc_lane #(
            .SAMPLE_WIDTH         (SAMPLE_WIDTH),
            .COUNT_WIDTH          (COUNT_WIDTH),
            .OFFSET_FRACTION_BITS (OFFSET_FRACTION_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_accel     (w_accel[a]),
            .i_gyro      (w_gyro[a]),
            .i_threshold (r_threshold),
            .i_count     (r_count),
            .o_stat      (w_stat[a])
        );
    end

    gbc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (w_stat),
        .i_load      (w_load),
        .i_kind      (r_res_kind),
        .i_ok        (r_res_ok),
        .o_any_moved (w_any_moved),
        .o_free      (w_out_free),
        .o_out       (o_out)
    );

    a_start_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.mode |=> r_phase == gbc_pkg::PH_CAL && r_count == '0)
        else $error("start request did not enter calibration");

    a_load_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == gbc_pkg::ST_PUSH))
        else $error("result appeared outside the push state");

    a_divide_in_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gbc_pkg::ST_DIVIDE |-> r_phase == gbc_pkg::PH_CAL)
        else $error("offset division outside calibration");

    a_motion_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gbc_pkg::ST_CHECK && w_any_moved |=>
            r_phase == gbc_pkg::PH_IDLE && r_state == gbc_pkg::ST_PUSH && !r_res_ok)
        else $error("motion did not abort calibration");

endmodule

// ===== hdl/gbc_lane.sv =====
// ----------------------------------------------------------------------------
// gbc_lane
// One gyro axis: motion check, bias sum, restoring divider for the offset,
// bias removal and 1/16.4 scaling.
// ----------------------------------------------------------------------------
module gbc_lane #(
    parameter int SAMPLE_WIDTH         = gbc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH          = gbc_pkg::COUNT_WIDTH_DEF,
    parameter int OFFSET_FRACTION_BITS = gbc_pkg::OFFSET_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gbc_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_accel,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_gyro,
    input  logic [gbc_pkg::THRESH_W-1:0]       i_threshold,
    input  logic [COUNT_WIDTH-1:0]             i_count,
    output gbc_pkg::t_lane_stat                o_stat
);

    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH + 1;
    localparam int DVD_W = SUM_W + OFFSET_FRACTION_BITS;
    localparam int OFS_W = SAMPLE_WIDTH + OFFSET_FRACTION_BITS;
    localparam int DIF_W = OFS_W + 1;
    localparam int MUL_W = DIF_W + gbc_pkg::SCALE_W;
    localparam int RSH   = gbc_pkg::SCALE_SHIFT + OFFSET_FRACTION_BITS;
    localparam int PRD_W = (MUL_W > RSH + gbc_pkg::RATE_W) ? MUL_W : RSH + gbc_pkg::RATE_W;
    localparam int MAG_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W = (MAG_W > gbc_pkg::THRESH_W) ? MAG_W : gbc_pkg::THRESH_W;
    localparam int ACC_W = (SAMPLE_WIDTH > gbc_pkg::ACCEL_OUT_W) ? SAMPLE_WIDTH
                                                                 : gbc_pkg::ACCEL_OUT_W;

    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic signed [SAMPLE_WIDTH-1:0] r_accel;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [OFS_W-1:0]        r_bias;
    logic                           r_moved;
    logic signed [DIF_W-1:0]        r_diff;
    logic signed [PRD_W-1:0]        r_prod;
    logic [COUNT_WIDTH-1:0]         r_rem;
    logic [DVD_W-1:0]               r_quo;
    logic                           r_neg;

    logic signed [MAG_W-1:0] w_delta;
    logic [MAG_W-1:0]        w_mag;
    logic                    w_moved;
    logic signed [DIF_W-1:0] w_unbiased;
    logic [SUM_W-1:0]        w_abs_sum;
    logic [COUNT_WIDTH-1:0]  w_dvs;
    logic [COUNT_WIDTH:0]    w_shift;
    logic [COUNT_WIDTH:0]    w_trial;
    logic signed [ACC_W-1:0] w_acc_wide;

    assign w_delta    = MAG_W'(i_gyro) - MAG_W'(r_prev);
    assign w_mag      = w_delta[MAG_W-1] ? MAG_W'(-w_delta) : MAG_W'(w_delta);
    assign w_moved    = CMP_W'(w_mag) > CMP_W'(i_threshold);
    assign w_unbiased = (DIF_W'(i_gyro) <<< OFFSET_FRACTION_BITS) - DIF_W'(r_bias);

    assign w_abs_sum = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_dvs     = (i_count == '0) ? COUNT_WIDTH'(1) : i_count;
    assign w_shift   = {r_rem, r_quo[DVD_W-1]};
    assign w_trial   = w_shift - {1'b0, w_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sum   <= '0;
            r_bias  <= '0;
            r_moved <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_sum <= '0;
            end
            if (i_ctl.sample_idle || i_ctl.sample_cal || i_ctl.sample_ready) begin
                r_prev <= i_gyro;
            end
            if (i_ctl.sample_cal) begin
                r_sum   <= r_sum + SUM_W'(i_gyro);
                r_moved <= w_moved;
            end
            if (i_ctl.div_finish) begin
                r_bias <= r_neg ? OFS_W'(-r_quo) : OFS_W'(r_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample_ready) begin
            r_accel <= i_accel;
            r_diff  <= w_unbiased;
        end
        if (i_ctl.scale) begin
            r_prod <= PRD_W'(r_diff) * PRD_W'(gbc_pkg::SCALE_MUL);
        end
        if (i_ctl.div_start) begin
            r_neg <= r_sum[SUM_W-1];
            r_rem <= '0;
            r_quo <= DVD_W'(w_abs_sum) << OFFSET_FRACTION_BITS;
        end else if (i_ctl.div_step) begin
            if (!w_trial[COUNT_WIDTH]) begin
                r_rem <= w_trial[COUNT_WIDTH-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[COUNT_WIDTH-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign w_acc_wide   = ACC_W'(r_accel);
    assign o_stat.moved = r_moved;
    assign o_stat.accel = w_acc_wide[gbc_pkg::ACCEL_OUT_W-1:0];
    assign o_stat.rate  = r_prod[RSH +: gbc_pkg::RATE_W];

endmodule

// ===== hdl/gbc_merge.sv =====
// ----------------------------------------------------------------------------
// gbc_merge
// Combines the axis lanes: motion flag reduction and the registered result
// stage that drives the output channel.
// ----------------------------------------------------------------------------
module gbc_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbc_pkg::t_lane_stat i_stat [gbc_pkg::NUM_AXES],
    input  logic                i_load,
    input  logic                i_kind,
    input  logic                i_ok,
    output logic                o_any_moved,
    output logic                o_free,
    gbc_out_if.source           o_out
);

    logic                                   r_valid;
    logic                                   r_kind;
    logic                                   r_ok;
    logic signed [gbc_pkg::ACCEL_OUT_W-1:0] r_accel [gbc_pkg::NUM_AXES];
    logic signed [gbc_pkg::RATE_W-1:0]      r_rate  [gbc_pkg::NUM_AXES];

    always_comb begin
        o_any_moved = 1'b0;
        for (int a = 0; a < gbc_pkg::NUM_AXES; a++) begin
            o_any_moved = o_any_moved | i_stat[a].moved;
        end
    end

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_kind;
            r_ok   <= (i_kind == gbc_pkg::KIND_CAL) && i_ok;
            for (int a = 0; a < gbc_pkg::NUM_AXES; a++) begin
                r_accel[a] <= (i_kind == gbc_pkg::KIND_DATA) ? i_stat[a].accel : '0;
                r_rate[a]  <= (i_kind == gbc_pkg::KIND_DATA) ? i_stat[a].rate  : '0;
            end
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_kind;
    assign o_out.calibration_ok = r_ok;
    assign o_out.accel_out_x    = r_accel[0];
    assign o_out.accel_out_y    = r_accel[1];
    assign o_out.accel_out_z    = r_accel[2];
    assign o_out.rate_x         = r_rate[0];
    assign o_out.rate_y         = r_rate[1];
    assign o_out.rate_z         = r_rate[2];

endmodule
